// File: sv/igs_pkg.sv
// ----------------------------------------------------------------------------
// igs_pkg: shared types for the intake gripper sequencer
// Word layouts, stage and operation codes, configuration register indexes.
// ----------------------------------------------------------------------------
package igs_pkg;

  localparam int unsigned DriveW = 16;
  localparam int unsigned TickW  = 16;

  typedef enum logic [1:0] {
    OP_MANUAL = 2'd0,
    OP_AUTO   = 2'd1,
    OP_HOLD   = 2'd2,
    OP_REINIT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    AGC_NONE  = 2'd0,
    AGC_SET   = 2'd1,
    AGC_CLEAR = 2'd2,
    AGC_SPARE = 2'd3
  } agc_e;

  typedef enum logic [2:0] {
    ST_BOTTOM = 3'd0,
    ST_INGEST = 3'd1,
    ST_WAIT   = 3'd2,
    ST_HOLD   = 3'd3,
    ST_EJECT  = 3'd4
  } stage_e;

  typedef enum logic [2:0] {
    CFG_INGEST_SPEED = 3'd0,
    CFG_EJECT_HIGH   = 3'd1,
    CFG_EJECT_LOW    = 3'd2,
    CFG_WAIT_TICKS   = 3'd3,
    CFG_EJECT_TICKS  = 3'd4
  } cfg_idx_e;

  localparam logic [TickW-1:0] WaitTicksRst  = TickW'(10);
  localparam logic [TickW-1:0] EjectTicksRst = TickW'(50);

  typedef struct packed {
    logic [1:0] operation;
    logic       cube_present;
    logic       grab_press_edge;
    logic       grab_held;
    logic       eject_held;
    logic       gentle_held;
    logic       manual_close;
    logic       lifter_at_bottom;
    logic       lifter_raise_done;
    logic [1:0] auto_grab_command;
  } igs_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    logic                     arms_open;
    logic                     lifter_raise_request;
    logic [2:0]               stage_now;
  } igs_out_t;

  typedef struct packed {
    logic signed [DriveW-1:0] ingest_speed;
    logic signed [DriveW-1:0] eject_high_speed;
    logic signed [DriveW-1:0] eject_low_speed;
    logic [TickW-1:0]         ingest_wait_ticks;
    logic [TickW-1:0]         eject_ticks;
  } igs_cfg_t;

endpackage

// File: sv/igs_cfg.sv
// ----------------------------------------------------------------------------
// igs_cfg: configuration register file
// Five 16-bit registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module igs_cfg import igs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [DriveW-1:0] cfg_data_i,
  output igs_cfg_t          cfg_o
);

  igs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ingest_speed      <= '0;
      cfg_q.eject_high_speed  <= '0;
      cfg_q.eject_low_speed   <= '0;
      cfg_q.ingest_wait_ticks <= WaitTicksRst;
      cfg_q.eject_ticks       <= EjectTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INGEST_SPEED: cfg_q.ingest_speed      <= cfg_data_i;
        CFG_EJECT_HIGH:   cfg_q.eject_high_speed  <= cfg_data_i;
        CFG_EJECT_LOW:    cfg_q.eject_low_speed   <= cfg_data_i;
        CFG_WAIT_TICKS:   cfg_q.ingest_wait_ticks <= cfg_data_i;
        CFG_EJECT_TICKS:  cfg_q.eject_ticks       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/igs_core.sv
// ----------------------------------------------------------------------------
// igs_core: sequencer state and per-tick next-state logic
// Updates stage, timer and flags for one word; returns the result word.
// ----------------------------------------------------------------------------
module igs_core import igs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  igs_in_t  word_i,
  input  igs_cfg_t cfg_i,
  output igs_out_t res_o
);

  stage_e           stage_q, stage_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic             arm_q, arm_d;
  logic             ag_q, ag_d;
  logic             ga_q, ga_d;
  logic             ge_q, ge_d;

  logic signed [DriveW-1:0] left;
  logic                     req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_INGEST;
      tick_q  <= '0;
      arm_q   <= 1'b0;
      ag_q    <= 1'b0;
      ga_q    <= 1'b0;
      ge_q    <= 1'b0;
    end else if (step_i) begin
      stage_q <= stage_d;
      tick_q  <= tick_d;
      arm_q   <= arm_d;
      ag_q    <= ag_d;
      ga_q    <= ga_d;
      ge_q    <= ge_d;
    end
  end

  always_comb begin
    stage_d = stage_q;
    arm_d   = arm_q;
    ga_d    = ga_q;
    ge_d    = ge_q;
    left    = '0;
    req     = 1'b0;

    case (agc_e'(word_i.auto_grab_command))
      AGC_SET:   ag_d = 1'b1;
      AGC_CLEAR: ag_d = 1'b0;
      default:   ag_d = ag_q;
    endcase

    tick_d = (tick_q == '1) ? tick_q : tick_q + TickW'(1);

    case (op_e'(word_i.operation))
      OP_REINIT: begin
        arm_d   = 1'b0;
        stage_d = ST_INGEST;
        tick_d  = '0;
        ag_d    = 1'b0;
        ga_d    = 1'b0;
      end
      OP_HOLD: begin
        stage_d = ST_HOLD;
      end
      OP_AUTO: begin
        if (stage_q == ST_HOLD) begin
          left    = ge_q ? cfg_i.eject_low_speed : cfg_i.eject_high_speed;
          tick_d  = '0;
          stage_d = ST_EJECT;
        end else if (stage_q == ST_EJECT) begin
          if (tick_d >= cfg_i.eject_ticks) begin
            arm_d   = 1'b1;
            stage_d = ST_INGEST;
          end else begin
            left = ge_q ? cfg_i.eject_low_speed : cfg_i.eject_high_speed;
          end
        end
      end
      default: begin
        case (stage_q)
          ST_BOTTOM: begin
            if (word_i.lifter_at_bottom) begin
              arm_d   = 1'b1;
              stage_d = ST_INGEST;
            end
          end
          ST_INGEST: begin
            if (word_i.grab_press_edge) ag_d = 1'b1;
            if (word_i.cube_present || word_i.manual_close) begin
              arm_d   = 1'b0;
              tick_d  = '0;
              left    = cfg_i.ingest_speed;
              ga_d    = 1'b0;
              ag_d    = 1'b0;
              stage_d = ST_WAIT;
            end else begin
              arm_d = 1'b1;
              if (ag_d) left = cfg_i.ingest_speed;
            end
          end
          ST_WAIT: begin
            if (tick_d > cfg_i.ingest_wait_ticks) begin
              req = 1'b1;
              if (word_i.lifter_raise_done) stage_d = ST_HOLD;
            end else begin
              left = cfg_i.ingest_speed;
            end
          end
          ST_HOLD: begin
            if (word_i.grab_press_edge) ga_d = 1'b1;
            if (ga_d && word_i.grab_held) begin
              left = cfg_i.ingest_speed;
            end else if (word_i.eject_held) begin
              if (word_i.gentle_held) ge_d = 1'b1;
              left    = ge_d ? cfg_i.eject_low_speed : cfg_i.eject_high_speed;
              tick_d  = '0;
              stage_d = ST_EJECT;
            end
          end
          ST_EJECT: begin
            // manual eject end restores the normal eject speed
            if (tick_d >= cfg_i.eject_ticks) begin
              arm_d   = 1'b1;
              ge_d    = 1'b0;
              stage_d = ST_INGEST;
            end else begin
              left = ge_q ? cfg_i.eject_low_speed : cfg_i.eject_high_speed;
            end
          end
          default: ;
        endcase
      end
    endcase

    res_o.left_drive  = left;
    // most negative drive has no positive twin: clamp
    res_o.right_drive = (left == {1'b1, {(DriveW-1){1'b0}}}) ?
                        {1'b0, {(DriveW-1){1'b1}}} : -left;
    res_o.arms_open            = arm_d;
    res_o.lifter_raise_request = req;
    res_o.stage_now            = stage_d;
  end

endmodule

// File: sv/intake_gripper_sequencer_top.sv
// ----------------------------------------------------------------------------
// intake_gripper_sequencer_top: cube intake sequencer
// Input register, sequencer core, result register and config registers.
// ----------------------------------------------------------------------------
// One input word is one control tick and yields exactly one result word.
// A word is taken into the input register, runs combinationally through the
// sequencer core (stage, tick timer, arm and grab flags) and lands in the
// result register, so the block sustains one word per cycle while the result
// side does not stall. The two registers decouple the sides: a stalled result
// holds while one further word can still enter an empty input register.
// Configuration is a plain indexed write port (0 ingest speed, 1 eject high
// speed, 2 eject low speed, 3 ingest wait ticks, 4 eject ticks); the user
// must write it only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module intake_gripper_sequencer_top import igs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input words
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  igs_in_t           in_word_i,
  // result words
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output igs_out_t          out_word_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [DriveW-1:0] cfg_data_i
);

  igs_cfg_t cfg;
  igs_in_t  in_q;
  logic     in_vld_q;
  igs_out_t res;
  igs_out_t out_q;
  logic     out_vld_q;
  logic     step;
  logic     in_take;

  // core steps when an input word is held and the result register is free or is drained this cycle
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  igs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  igs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule
